// ===== src/trapezoid_membership_macros.svh =====
// Assertion macros for the trapezoid membership block.
// Clocked on clock, disabled during reset; used by trapezoid_membership.
`ifndef TRAPEZOID_MEMBERSHIP_MACROS_SVH
`define TRAPEZOID_MEMBERSHIP_MACROS_SVH

// Same-cycle implication
`define TPM_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define TPM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/tpm_pkg.sv =====
// Shared constants and types for the trapezoid membership block.
// No dependencies; used by tpm_ramp_div and trapezoid_membership.
package tpm_pkg;

   localparam int unsigned DataWidth = 16;
   localparam int unsigned QuotBits  = 15;
   localparam int unsigned AddrWidth = 3;

   localparam logic [DataWidth-1:0] OneQ15 = 16'h8000;

   // Register indexes of the configuration port
   typedef enum logic [AddrWidth-1:0] {
      CSR_VERTEX_A    = 3'd0,
      CSR_VERTEX_B    = 3'd1,
      CSR_VERTEX_C    = 3'd2,
      CSR_VERTEX_D    = 3'd3,
      CSR_LEFT_OPEN   = 3'd4,
      CSR_RIGHT_OPEN  = 3'd5,
      CSR_PEAK_HEIGHT = 3'd6
   } csr_idx_type;

   // One ramp operation handed to the divider: either a forced result or
   // magnitudes with num < den to be divided
   typedef struct packed {
      logic                 force_en;
      logic                 force_one;
      logic [DataWidth-1:0] num;
      logic [DataWidth-1:0] den;
   } ramp_op_type;

endpackage

// ===== src/tpm_ramp_div.sv =====
// Pipelined restoring divider for one ramp: one quotient bit per stage.
// Depends on tpm_pkg; stage loads come from the valid/ready chain of the top level.
module tpm_ramp_div (
   input  logic                                clock,
   input  logic [tpm_pkg::QuotBits-1:0]        load,
   input  tpm_pkg::ramp_op_type                op,
   output logic [tpm_pkg::DataWidth-1:0]       ramp
);

   localparam int unsigned Dw = tpm_pkg::DataWidth;
   localparam int unsigned Qb = tpm_pkg::QuotBits;

   logic [Dw-1:0] rem_ff  [Qb];
   logic [Dw-1:0] rem_in  [Qb];
   logic [Dw-1:0] den_ff  [Qb];
   logic [Dw-1:0] den_in  [Qb];
   logic [Qb-1:0] quo_ff  [Qb];
   logic [Qb-1:0] quo_in  [Qb];
   logic          fen_ff  [Qb];
   logic          fen_in  [Qb];
   logic          fone_ff [Qb];
   logic          fone_in [Qb];

   // One trial subtraction per stage
   for (genvar k = 0; k < Qb; k++) begin : g_stage
      logic [Dw-1:0] rem_src;
      logic [Dw-1:0] den_src;
      logic [Qb-1:0] quo_src;
      logic          fen_src;
      logic          fone_src;
      logic [Dw:0]   shifted;
      logic [Dw+1:0] diff;
      logic          take;

      if (k == 0) begin : g_first
         assign rem_src  = op.num;
         assign den_src  = op.den;
         assign quo_src  = '0;
         assign fen_src  = op.force_en;
         assign fone_src = op.force_one;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign den_src  = den_ff[k-1];
         assign quo_src  = quo_ff[k-1];
         assign fen_src  = fen_ff[k-1];
         assign fone_src = fone_ff[k-1];
      end

      assign shifted  = {rem_src, 1'b0};
      assign diff     = {1'b0, shifted} - {2'b00, den_src};
      assign take     = ~diff[Dw+1];
      assign rem_in[k]  = take ? diff[Dw-1:0] : shifted[Dw-1:0];
      assign den_in[k]  = den_src;
      assign quo_in[k]  = {quo_src[Qb-2:0], take};
      assign fen_in[k]  = fen_src;
      assign fone_in[k] = fone_src;
   end

   // Advance each stage when its slot is free or moving on
   always_ff @(posedge clock) begin
      for (int k = 0; k < Qb; k++) begin
         if (load[k]) begin
            rem_ff[k]  <= rem_in[k];
            den_ff[k]  <= den_in[k];
            quo_ff[k]  <= quo_in[k];
            fen_ff[k]  <= fen_in[k];
            fone_ff[k] <= fone_in[k];
         end
      end
   end

   // Pick forced value or quotient from the last stage
   always_comb begin
      if (fen_ff[Qb-1]) begin
         ramp = fone_ff[Qb-1] ? tpm_pkg::OneQ15 : '0;
      end else begin
         ramp = {{(Dw-Qb){1'b0}}, quo_ff[Qb-1]};
      end
   end

endmodule

// ===== src/trapezoid_membership.sv =====
// Trapezoid membership: sample in, degree = membership * height out, Q1.15.
// One beat per cycle while rsp_tready is high or any stage is free.
// Most of the depth is two 15-stage restoring dividers side by side, one per ramp.
// Bubbles close up behind a stalled rsp beat, so req stays open while any stage is free.
// Reset (synchronous) empties the pipeline and restores the register defaults.
// Depends on tpm_pkg, tpm_ramp_div and trapezoid_membership_macros.svh.
`include "trapezoid_membership_macros.svh"

module trapezoid_membership (
   input  logic                                  clock,
   input  logic                                  reset,
   // req_tdata: [15:0] sample
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [tpm_pkg::DataWidth-1:0]         req_tdata,
   // rsp_tdata: [15:0] degree
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [tpm_pkg::DataWidth-1:0]         rsp_tdata,
   input  logic                                  csr_we,
   input  logic [tpm_pkg::AddrWidth-1:0]         csr_addr,
   input  logic [tpm_pkg::DataWidth-1:0]         csr_wdata
);

   localparam int unsigned Dw        = tpm_pkg::DataWidth;
   localparam int unsigned Qb        = tpm_pkg::QuotBits;
   localparam int unsigned SDiff     = 0;
   localparam int unsigned SAbs      = 1;
   localparam int unsigned SCls      = 2;
   localparam int unsigned DivBase   = 3;
   localparam int unsigned MinStage  = DivBase + Qb;
   localparam int unsigned OutStage  = MinStage + 1;
   localparam int unsigned NumStages = OutStage + 1;

   // Magnitude of a 17-bit signed difference
   function automatic logic [Dw-1:0] mag_of(input logic signed [Dw:0] v);
      logic [Dw:0] t;
      t = v[Dw] ? (~v + {{Dw{1'b0}}, 1'b1}) : v;
      return t[Dw-1:0];
   endfunction

   // Decide a forced ramp value or hand magnitudes to the divider
   function automatic tpm_pkg::ramp_op_type classify(input logic full, input logic open,
                                                     input logic num_neg, input logic den_neg,
                                                     input logic [Dw-1:0] num_mag,
                                                     input logic [Dw-1:0] den_mag);
      tpm_pkg::ramp_op_type op;
      op.num       = num_mag;
      op.den       = den_mag;
      op.force_en  = 1'b1;
      op.force_one = 1'b1;
      if (full || open) begin
         op.force_one = 1'b1;
      end else if (den_mag == '0) begin
         op.force_one = ~num_neg;
      end else if (num_mag == '0 || num_neg != den_neg) begin
         op.force_one = 1'b0;
      end else if (num_mag >= den_mag) begin
         op.force_one = 1'b1;
      end else begin
         op.force_en  = 1'b0;
      end
      return op;
   endfunction

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic signed [Dw-1:0] vertex_a_ff, vertex_b_ff, vertex_c_ff, vertex_d_ff;
   logic                 left_open_ff, right_open_ff;
   logic [Dw-1:0]        height_ff;
   logic [Dw-1:0]        height_in;

   // Store the height already limited to one
   assign height_in = (csr_wdata > tpm_pkg::OneQ15) ? tpm_pkg::OneQ15 : csr_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_a_ff   <= 16'sd0;
         vertex_b_ff   <= 16'sd1024;
         vertex_c_ff   <= 16'sd2048;
         vertex_d_ff   <= 16'sd3072;
         left_open_ff  <= 1'b0;
         right_open_ff <= 1'b0;
         height_ff     <= tpm_pkg::OneQ15;
      end else if (csr_we) begin
         case (tpm_pkg::csr_idx_type'(csr_addr))
            tpm_pkg::CSR_VERTEX_A:    vertex_a_ff   <= csr_wdata;
            tpm_pkg::CSR_VERTEX_B:    vertex_b_ff   <= csr_wdata;
            tpm_pkg::CSR_VERTEX_C:    vertex_c_ff   <= csr_wdata;
            tpm_pkg::CSR_VERTEX_D:    vertex_d_ff   <= csr_wdata;
            tpm_pkg::CSR_LEFT_OPEN:   left_open_ff  <= csr_wdata[0];
            tpm_pkg::CSR_RIGHT_OPEN:  right_open_ff <= csr_wdata[0];
            tpm_pkg::CSR_PEAK_HEIGHT: height_ff     <= height_in;
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Valid bits and per-stage ready
   // ---------------------------------------------------------------
   logic [NumStages-1:0] vld_ff, vld_in, rdy;

   // A stage may load when rsp is taken or any slot from it onwards is empty
   always_comb begin
      for (int i = 0; i < NumStages; i++) begin
         rdy[i] = rsp_tready || (((~vld_ff) >> i) != '0);
      end
      vld_in[0] = req_tvalid;
      for (int i = 1; i < NumStages; i++) begin
         vld_in[i] = vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NumStages; i++) begin
            if (rdy[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   assign req_tready = rdy[SDiff];

   // ---------------------------------------------------------------
   // Stage 0: differences and shoulder tests
   // ---------------------------------------------------------------
   logic signed [Dw-1:0] sample;
   logic signed [Dw:0]   rnum_ff, rden_ff, fnum_ff, fden_ff;
   logic signed [Dw:0]   rnum_in, rden_in, fnum_in, fden_in;
   logic                 full_ff, full_in;

   assign sample  = req_tdata;
   assign rnum_in = {sample[Dw-1], sample} - {vertex_a_ff[Dw-1], vertex_a_ff};
   assign rden_in = {vertex_b_ff[Dw-1], vertex_b_ff} - {vertex_a_ff[Dw-1], vertex_a_ff};
   assign fnum_in = {vertex_d_ff[Dw-1], vertex_d_ff} - {sample[Dw-1], sample};
   assign fden_in = {vertex_d_ff[Dw-1], vertex_d_ff} - {vertex_c_ff[Dw-1], vertex_c_ff};
   assign full_in = (left_open_ff && sample <= vertex_b_ff)
                 || (right_open_ff && sample > vertex_c_ff);

   always_ff @(posedge clock) begin
      if (rdy[SDiff]) begin
         rnum_ff <= rnum_in;
         rden_ff <= rden_in;
         fnum_ff <= fnum_in;
         fden_ff <= fden_in;
         full_ff <= full_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: signs and magnitudes
   // ---------------------------------------------------------------
   logic          rnneg_ff, rdneg_ff, fnneg_ff, fdneg_ff, full1_ff;
   logic [Dw-1:0] rnmag_ff, rdmag_ff, fnmag_ff, fdmag_ff;

   always_ff @(posedge clock) begin
      if (rdy[SAbs]) begin
         rnneg_ff <= rnum_ff[Dw];
         rdneg_ff <= rden_ff[Dw];
         fnneg_ff <= fnum_ff[Dw];
         fdneg_ff <= fden_ff[Dw];
         rnmag_ff <= mag_of(rnum_ff);
         rdmag_ff <= mag_of(rden_ff);
         fnmag_ff <= mag_of(fnum_ff);
         fdmag_ff <= mag_of(fden_ff);
         full1_ff <= full_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: special cases and divider operands
   // ---------------------------------------------------------------
   tpm_pkg::ramp_op_type rop_ff, fop_ff, rop_in, fop_in;

   assign rop_in = classify(full1_ff, left_open_ff, rnneg_ff, rdneg_ff, rnmag_ff, rdmag_ff);
   assign fop_in = classify(full1_ff, right_open_ff, fnneg_ff, fdneg_ff, fnmag_ff, fdmag_ff);

   always_ff @(posedge clock) begin
      if (rdy[SCls]) begin
         rop_ff <= rop_in;
         fop_ff <= fop_in;
      end
   end

   // ---------------------------------------------------------------
   // Dividers for the rising and falling ramps
   // ---------------------------------------------------------------
   logic [Dw-1:0] rise_ramp, fall_ramp;

   tpm_ramp_div u_rise_div (
      .clock (clock),
      .load  (rdy[DivBase +: Qb]),
      .op    (rop_ff),
      .ramp  (rise_ramp)
   );

   tpm_ramp_div u_fall_div (
      .clock (clock),
      .load  (rdy[DivBase +: Qb]),
      .op    (fop_ff),
      .ramp  (fall_ramp)
   );

   // ---------------------------------------------------------------
   // Minimum of the two ramps, then scale by the height
   // ---------------------------------------------------------------
   logic [Dw-1:0]   memb_ff, memb_in;
   logic [2*Dw-1:0] prod;
   logic [Dw-1:0]   degree_ff, degree_in;

   assign memb_in   = (rise_ramp < fall_ramp) ? rise_ramp : fall_ramp;
   assign prod      = {{Dw{1'b0}}, memb_ff} * {{Dw{1'b0}}, height_ff};
   assign degree_in = prod[Qb +: Dw];

   always_ff @(posedge clock) begin
      if (rdy[MinStage]) begin
         memb_ff <= memb_in;
      end
      if (rdy[OutStage]) begin
         degree_ff <= degree_in;
      end
   end

   assign rsp_tvalid = vld_ff[OutStage];
   assign rsp_tdata  = degree_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `TPM_ASSERT_IMPLY(a_degree_max, rsp_tvalid, rsp_tdata <= tpm_pkg::OneQ15, "degree above one")
   `TPM_ASSERT_IMPLY(a_div_operands, vld_ff[SCls] && !rop_ff.force_en,
                     rop_ff.num < rop_ff.den, "rise divider given num >= den")
   `TPM_ASSERT_IMPLY(a_ready_on_bubble, !(&vld_ff), req_tready, "req blocked with a free slot")
   `TPM_ASSERT_NEXT(a_accept_lands, req_tvalid && req_tready, vld_ff[SDiff],
                    "accepted beat missing from first stage")

endmodule

// ===== bench/trapezoid_membership_tb.sv =====
// Self-checking bench for trapezoid_membership: directed shapes, then random traffic.
// Predicts each degree locally from the written registers; needs tpm_pkg and the RTL.
module trapezoid_membership_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ResetCycles = 9;
   localparam int PipeLatency = 20;
   localparam int MaxReports  = 10;
   localparam int FullDegree  = int'(tpm_pkg::OneQ15);

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [tpm_pkg::DataWidth-1:0] req_tdata = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [tpm_pkg::DataWidth-1:0] rsp_tdata;
   logic                          csr_we = 1'b0;
   logic [tpm_pkg::AddrWidth-1:0] csr_addr = '0;
   logic [tpm_pkg::DataWidth-1:0] csr_wdata = '0;

   // Local copy of the shape registers, reset values
   logic signed [15:0] shape_a = 16'sd0;
   logic signed [15:0] shape_b = 16'sd1024;
   logic signed [15:0] shape_c = 16'sd2048;
   logic signed [15:0] shape_d = 16'sd3072;
   logic               left_open_q = 1'b0;
   logic               right_open_q = 1'b0;
   logic [15:0]        height_q = tpm_pkg::OneQ15;

   logic [15:0] pending_degrees[$];
   int          degree_errors = 0;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;

   trapezoid_membership uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [15:0] sample
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [15:0] degree
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Q1.15 ramp quotient, truncated and clamped; a zero denominator is a step
   function automatic int ramp_fraction(int num, int den);
      longint mag_n;
      longint mag_d;
      longint quot;
      if (den == 0) return (num >= 0) ? FullDegree : 0;
      if (num == 0 || ((num < 0) != (den < 0))) return 0;
      mag_n = (num < 0) ? -longint'(num) : longint'(num);
      mag_d = (den < 0) ? -longint'(den) : longint'(den);
      quot  = (mag_n << 15) / mag_d;
      return (quot > FullDegree) ? FullDegree : int'(quot);
   endfunction

   // Membership of one sample under the current shape, scaled by the height
   function automatic logic [15:0] membership_degree(logic signed [15:0] sample);
      int     x;
      int     va;
      int     vb;
      int     vc;
      int     vd;
      int     rise;
      int     fall;
      int     m;
      int     h;
      longint scaled;
      x  = sample;
      va = shape_a;
      vb = shape_b;
      vc = shape_c;
      vd = shape_d;
      if (left_open_q && x <= vb) begin
         m = FullDegree;
      end else if (right_open_q && x > vc) begin
         m = FullDegree;
      end else begin
         rise = left_open_q ? FullDegree : ramp_fraction(x - va, vb - va);
         fall = right_open_q ? FullDegree : ramp_fraction(vd - x, vd - vc);
         m    = (rise < fall) ? rise : fall;
      end
      h      = (height_q > tpm_pkg::OneQ15) ? FullDegree : int'(height_q);
      scaled = (longint'(m) * h) >> 15;
      return scaled[15:0];
   endfunction

   function automatic logic [15:0] sat16(int v);
      if (v > 32767) return 16'h7FFF;
      if (v < -32768) return 16'h8000;
      return v[15:0];
   endfunction

   task automatic note_error(string msg);
      degree_errors++;
      if (degree_errors <= MaxReports) $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   // Receiver: change tready on the falling edge at the current stall rate
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Compare each rsp beat with the oldest predicted degree
   always @(posedge clock) begin
      logic [15:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_degrees.size() == 0) begin
            note_error($sformatf("unexpected rsp beat, degree %0d", rsp_tdata));
         end else begin
            want = pending_degrees.pop_front();
            if (rsp_tdata !== want)
               note_error($sformatf("degree expected %0d, got %0d", want, rsp_tdata));
         end
      end
   end

   task automatic write_reg(tpm_pkg::csr_idx_type idx, logic [15:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         tpm_pkg::CSR_VERTEX_A:    shape_a = value;
         tpm_pkg::CSR_VERTEX_B:    shape_b = value;
         tpm_pkg::CSR_VERTEX_C:    shape_c = value;
         tpm_pkg::CSR_VERTEX_D:    shape_d = value;
         tpm_pkg::CSR_LEFT_OPEN:   left_open_q = value[0];
         tpm_pkg::CSR_RIGHT_OPEN:  right_open_q = value[0];
         tpm_pkg::CSR_PEAK_HEIGHT: height_q = value;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_shape(int a, int b, int c, int d, bit lo, bit ro, int h);
      write_reg(tpm_pkg::CSR_VERTEX_A, sat16(a));
      write_reg(tpm_pkg::CSR_VERTEX_B, sat16(b));
      write_reg(tpm_pkg::CSR_VERTEX_C, sat16(c));
      write_reg(tpm_pkg::CSR_VERTEX_D, sat16(d));
      write_reg(tpm_pkg::CSR_LEFT_OPEN, {15'b0, lo});
      write_reg(tpm_pkg::CSR_RIGHT_OPEN, {15'b0, ro});
      write_reg(tpm_pkg::CSR_PEAK_HEIGHT, h[15:0]);
   endtask

   // Offer one req beat after a random gap; record its degree once taken
   task automatic send_sample(logic [15:0] sample);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      do @(posedge clock); while (!req_tready);
      pending_degrees.push_back(membership_degree(sample));
   endtask

   // Drop valid and wait for every outstanding degree, plus the pipe depth if asked
   task automatic drain_results(bit hold_extra);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_degrees.size() != 0) @(posedge clock);
      if (hold_extra) repeat (PipeLatency + 4) @(posedge clock);
   endtask

   // Random shape: compact, sorted, scrambled, stepped or wide
   task automatic randomise_shape();
      int v[4];
      int base;
      int h;
      base = int'($urandom_range(0, 65535)) - 32768;
      case ($urandom_range(0, 4))
         0: begin
            v[0] = base;
            v[1] = v[0] + int'($urandom_range(0, 300));
            v[2] = v[1] + int'($urandom_range(0, 300));
            v[3] = v[2] + int'($urandom_range(0, 300));
         end
         1: begin
            foreach (v[i]) v[i] = int'($urandom_range(0, 65535)) - 32768;
            v.sort();
         end
         2: begin
            foreach (v[i]) v[i] = int'($urandom_range(0, 65535)) - 32768;
         end
         3: begin
            v[0] = base;
            v[1] = base;
            v[2] = base + int'($urandom_range(0, 500));
            v[3] = v[2];
         end
         default: begin
            v[0] = -32768 + int'($urandom_range(0, 200));
            v[3] = 32767 - int'($urandom_range(0, 200));
            v[1] = int'($urandom_range(0, 20000)) - 10000;
            v[2] = v[1] + int'($urandom_range(0, 5000));
         end
      endcase
      case ($urandom_range(0, 5))
         0: h = FullDegree;
         1: h = 0;
         2: h = int'($urandom_range(FullDegree + 1, 65535));
         default: h = int'($urandom_range(0, FullDegree));
      endcase
      apply_shape(v[0], v[1], v[2], v[3], ($urandom_range(0, 3) == 0),
                  ($urandom_range(0, 3) == 0), h);
   endtask

   // Mostly samples around the vertices, some anywhere, some at the rails
   function automatic logic [15:0] pick_sample();
      int x;
      int lo;
      int hi;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: begin
            case ($urandom_range(0, 3))
               0: x = shape_a;
               1: x = shape_b;
               2: x = shape_c;
               default: x = shape_d;
            endcase
            x = x + int'($urandom_range(0, 40)) - 20;
         end
         5, 6: begin
            lo = (shape_a < shape_d) ? shape_a : shape_d;
            hi = (shape_a < shape_d) ? shape_d : shape_a;
            x  = lo + int'($urandom_range(0, hi - lo));
         end
         7, 8: x = int'($urandom_range(0, 65535)) - 32768;
         default: x = $urandom_range(0, 1) ? -32768 : 32767;
      endcase
      return sat16(x);
   endfunction

   task automatic test_reset_defaults();
      int pts[8] = '{-32768, 0, 512, 1024, 2048, 2560, 3072, 32767};
      foreach (pts[i]) send_sample(sat16(pts[i]));
   endtask

   task automatic test_open_shoulders();
      int left_pts[4]  = '{-32768, 100, 101, 300};
      int right_pts[4] = '{199, 200, 201, 32767};
      drain_results(1'b1);
      apply_shape(-100, 100, 200, 400, 1'b1, 1'b0, 20000);
      foreach (left_pts[i]) send_sample(sat16(left_pts[i]));
      drain_results(1'b1);
      apply_shape(-100, 100, 200, 400, 1'b0, 1'b1, 20000);
      foreach (right_pts[i]) send_sample(sat16(right_pts[i]));
   endtask

   task automatic test_zero_width_ramps();
      int pts[4] = '{499, 500, 900, 901};
      drain_results(1'b1);
      apply_shape(500, 500, 900, 900, 1'b0, 1'b0, 65535);
      foreach (pts[i]) send_sample(sat16(pts[i]));
   endtask

   task automatic test_reversed_and_extremes();
      int pts[4] = '{-2000, 0, 1700, 32767};
      drain_results(1'b1);
      apply_shape(1000, -1000, 2000, 1500, 1'b0, 1'b0, 12345);
      foreach (pts[i]) send_sample(sat16(pts[i]));
      // widest possible ramps, zero height
      drain_results(1'b1);
      apply_shape(-32768, 32767, -32768, 32767, 1'b0, 1'b0, 0);
      send_sample(16'h8000);
      send_sample(16'h7FFF);
   endtask

   // Three random shapes per idling mix; hold the sender once until all degrees are back
   task automatic test_random_traffic(int idle_pct, int stall_pct);
      for (int shape = 0; shape < 3; shape++) begin
         drain_results(1'b1);
         randomise_shape();
         send_idle_pct = idle_pct;
         rsp_stall_pct = stall_pct;
         for (int n = 0; n < 60; n++) begin
            if (shape == 1 && n == 30) drain_results(1'b0);
            send_sample(pick_sample());
         end
      end
   endtask

   initial begin
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_open_shoulders();
      test_zero_width_ramps();
      test_reversed_and_extremes();
      test_random_traffic(0, 0);
      test_random_traffic(80, 0);
      test_random_traffic(0, 80);
      test_random_traffic(21, 21);
      drain_results(1'b1);
      if (degree_errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
